/* sv/mhl_pkg.sv */
// shared constants, command codes and cell select type for the mru history list
package mhl_pkg;

  localparam int unsigned DepthDefault   = 16;
  localparam int unsigned KeyBitsDefault = 16;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned KeyW   = 16;
  localparam int unsigned PosW   = 4;
  localparam int unsigned CapW   = 5;
  localparam int unsigned LenW   = 5;

  localparam logic [CapW-1:0] CapReset = CapW'(10);

  localparam logic [CmdW-1:0] CmdAdd    = 2'd0;
  localparam logic [CmdW-1:0] CmdRemove = 2'd1;
  localparam logic [CmdW-1:0] CmdClear  = 2'd2;
  localparam logic [CmdW-1:0] CmdRead   = 2'd3;

  // where a cell takes its next key from
  typedef enum logic [1:0] {
    SelHold  = 2'd0,
    SelKey   = 2'd1,
    SelLeft  = 2'd2,
    SelRight = 2'd3
  } cell_sel_e;

endpackage

/* sv/mhl_cell.sv */
// one list slot: holds a key, compares it, and loads from itself, the input key or a neighbor
module mhl_cell #(
  parameter int unsigned KEY_BITS = mhl_pkg::KeyBitsDefault
) (
  input  logic                clk_i,
  input  mhl_pkg::cell_sel_e  sel_i,
  input  logic                live_i,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic [KEY_BITS-1:0] left_i,
  input  logic [KEY_BITS-1:0] right_i,
  output logic [KEY_BITS-1:0] key_o,
  output logic                match_o
);
  import mhl_pkg::*;

  logic [KEY_BITS-1:0] key_q, key_d;

  always_comb begin
    case (sel_i)
      SelKey:   key_d = key_i;
      SelLeft:  key_d = left_i;
      SelRight: key_d = right_i;
      default:  key_d = key_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o   = key_q;
  assign match_o = live_i && (key_q == key_i);

endmodule

/* sv/mru_history_list.sv */
// top level of the mru history list: cell row, length counter and result register
//
// most-recently-used list of distinct keys, position 0 is the most recent
// command channel: an item is taken at a clock edge with start high and busy low;
// busy is always low, so a new command can be issued every cycle
// commands: add moves a key to the front (dropping the entry at position
// capacity when the list overflows), remove deletes a key, clear empties the
// list, read returns the key at a position
// result channel: exactly one result per command, shown for one cycle with
// done_o high, in the cycle after the command is taken
// throughput: one command per cycle, set by the row of cells that compares
// every slot against the key and shifts in the same cycle
// the receiver cannot stall; it must take each result in its strobe cycle
// config channel: cfg_valid_i/cfg_ready_o write the capacity register
// (ready always high); capacity 0 acts as 1, above DEPTH it saturates
// reset: list length goes to zero and capacity to 10; slot contents are not
// cleared, since only slots below the length are ever read
module mru_history_list #(
  parameter int unsigned DEPTH    = mhl_pkg::DepthDefault,
  parameter int unsigned KEY_BITS = mhl_pkg::KeyBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [mhl_pkg::CmdW-1:0]  command_i,
  input  logic [mhl_pkg::KeyW-1:0]  key_i,
  input  logic [mhl_pkg::PosW-1:0]  position_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [mhl_pkg::CapW-1:0]  cfg_data_i,
  output logic                      done_o,
  output logic [mhl_pkg::KeyW-1:0]  entry_key_o,
  output logic                      entry_valid_o,
  output logic [mhl_pkg::LenW-1:0]  list_length_o,
  output logic                      changed_o
);
  import mhl_pkg::*;

  // count width holds 0..DEPTH; wide compare width covers count, capacity and position
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned MW = (CW > CapW) ? CW : CapW;

  logic [CapW-1:0]     cap_q;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       eff_cap;

  logic [KEY_BITS-1:0] key_in;
  logic [KEY_BITS-1:0] cell_key [DEPTH];
  logic [DEPTH-1:0]    match;
  logic [DEPTH-1:0]    live;
  cell_sel_e           sel [DEPTH];

  logic                found;
  logic [CW-1:0]       where_idx;
  logic                add_go, rem_go, clr_go, rd_go;
  logic [CW:0]         n_pre;
  logic                drop;
  logic                rd_valid;
  logic [KEY_BITS-1:0] rd_key;

  logic                done_q;
  logic [KeyW-1:0]     entry_key_q;
  logic                entry_valid_q;
  logic [LenW-1:0]     list_length_q;
  logic                changed_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign key_in      = KEY_BITS'(key_i);

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // clamp capacity to 1..DEPTH
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CW'(1);
    end else if (MW'(cap_q) > MW'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = CW'(cap_q);
    end
  end

  // key lookup; keys are distinct, so at most one slot matches
  always_comb begin
    found     = |match;
    where_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match[i]) begin
        where_idx = where_idx | CW'(i);
      end
    end
  end

  assign add_go = start && (command_i == CmdAdd) && !match[0];
  assign rem_go = start && (command_i == CmdRemove) && found;
  assign clr_go = start && (command_i == CmdClear) && (cnt_q != '0);
  assign rd_go  = start && (command_i == CmdRead);

  // length after inserting, before dropping the overflow slot
  assign n_pre = found ? {1'b0, cnt_q} : ({1'b0, cnt_q} + (CW+1)'(1));
  assign drop  = n_pre > {1'b0, eff_cap};

  // per-slot load select
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      sel[i] = SelHold;
      if (add_go) begin
        if (drop && (CW'(i) >= eff_cap)) begin
          // slot takes what would have been one further down
          if (found && (CW'(i + 1) > where_idx)) begin
            sel[i] = SelRight;
          end else begin
            sel[i] = SelHold;
          end
        end else if (i == 0) begin
          sel[i] = SelKey;
        end else if (found && (CW'(i) > where_idx)) begin
          sel[i] = SelHold;
        end else begin
          sel[i] = SelLeft;
        end
      end else if (rem_go) begin
        if (CW'(i) >= where_idx) begin
          sel[i] = SelRight;
        end
      end
    end
  end

  // the row of slots
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KEY_BITS-1:0] left_key;
    logic [KEY_BITS-1:0] right_key;

    if (g == 0) begin : g_first
      assign left_key = key_in;
    end else begin : g_mid
      assign left_key = cell_key[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_key = cell_key[g];
    end else begin : g_inner
      assign right_key = cell_key[g+1];
    end

    assign live[g] = CW'(g) < cnt_q;

    mhl_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .sel_i   (sel[g]),
      .live_i  (live[g]),
      .key_i   (key_in),
      .left_i  (left_key),
      .right_i (right_key),
      .key_o   (cell_key[g]),
      .match_o (match[g])
    );
  end

  // length counter
  always_comb begin
    cnt_d = cnt_q;
    if (add_go) begin
      cnt_d = drop ? CW'(n_pre - (CW+1)'(1)) : CW'(n_pre);
    end else if (rem_go) begin
      cnt_d = cnt_q - CW'(1);
    end else if (clr_go) begin
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // read port over the row
  assign rd_valid = rd_go && (MW'(position_i) < MW'(cnt_q)) && (MW'(position_i) < MW'(DEPTH));

  always_comb begin
    rd_key = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (MW'(position_i) == MW'(i)) begin
        rd_key = rd_key | cell_key[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      entry_key_q   <= rd_valid ? KeyW'(rd_key) : '0;
      entry_valid_q <= rd_valid;
      list_length_q <= LenW'(cnt_d);
      changed_q     <= add_go || rem_go || clr_go;
    end
  end

  assign done_o        = done_q;
  assign entry_key_o   = entry_key_q;
  assign entry_valid_o = entry_valid_q;
  assign list_length_o = list_length_q;
  assign changed_o     = changed_q;

endmodule

/* test/mru_history_list_checker.sv */
// checker for the mru history list: tracks the recency list and compares every result
`timescale 1ns / 100ps

module mru_history_list_checker
  import mhl_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            busy_i,
  input  logic [CmdW-1:0] command_i,
  input  logic [KeyW-1:0] key_i,
  input  logic [PosW-1:0] position_i,
  input  logic            cfg_valid_i,
  input  logic            cfg_ready_i,
  input  logic [CapW-1:0] cfg_data_i,
  input  logic            done_i,
  input  logic [KeyW-1:0] entry_key_i,
  input  logic            entry_valid_i,
  input  logic [LenW-1:0] list_length_i,
  input  logic            changed_i,
  output int              fail_count_o,
  output int              pending_o
);

  localparam int unsigned Depth = DepthDefault;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            valid;
    logic [LenW-1:0] len;
    logic            chg;
  } lookup_result_t;

  // our own copy of the list, in recency order
  logic [KeyW-1:0] slots [Depth];
  int unsigned     used_len;
  logic [CapW-1:0] cap_reg;
  lookup_result_t  results_due [$];
  lookup_result_t  want;

  function automatic int unsigned eff_cap();
    int unsigned c;
    c = 32'(cap_reg);
    if (c < 1) c = 1;
    if (c > Depth) c = Depth;
    return c;
  endfunction

  function automatic int find_slot(logic [KeyW-1:0] k);
    int i;
    for (i = 0; i < int'(used_len); i++) begin
      if (slots[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic void drop_slot(int unsigned p);
    int unsigned i;
    for (i = p; i + 1 < used_len; i++) slots[i] = slots[i + 1];
    used_len--;
  endfunction

  // add: key to the front, older copy removed, entry at position cap dropped on overflow
  function automatic bit move_to_front(logic [KeyW-1:0] k);
    logic [KeyW-1:0] row [Depth + 1];
    int unsigned     n;
    int unsigned     cap;
    int unsigned     i;
    int              hit;
    if (used_len > 0 && slots[0] == k) return 1'b0;
    hit = find_slot(k);
    if (hit >= 0) drop_slot(hit);
    row[0] = k;
    for (i = 0; i < used_len; i++) row[i + 1] = slots[i];
    n = used_len + 1;
    cap = eff_cap();
    if (n > cap) begin
      for (i = cap; i + 1 < n; i++) row[i] = row[i + 1];
      n--;
    end
    if (n > Depth) n = Depth;
    for (i = 0; i < n; i++) slots[i] = row[i];
    used_len = n;
    return 1'b1;
  endfunction

  function automatic lookup_result_t predict_lookup(logic [CmdW-1:0] cmd,
                                                    logic [KeyW-1:0] k,
                                                    logic [PosW-1:0] pos);
    lookup_result_t r;
    int             hit;
    r = '0;
    case (cmd)
      CmdAdd: begin
        r.chg = move_to_front(k);
      end
      CmdRemove: begin
        hit = find_slot(k);
        if (hit >= 0) begin
          drop_slot(hit);
          r.chg = 1'b1;
        end
      end
      CmdClear: begin
        if (used_len > 0) begin
          used_len = 0;
          r.chg = 1'b1;
        end
      end
      default: begin
        if (pos < used_len) begin
          r.key   = slots[pos];
          r.valid = 1'b1;
        end
      end
    endcase
    r.len = LenW'(used_len);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_len = 0;
      cap_reg = CapReset;
      results_due.delete();
      pending_o = 0;
      fail_count_o = 0;
    end else begin
      if (done_i) begin
        if (results_due.size() == 0) begin
          $display("%0t: result expected none actual key %0h valid %0b len %0d chg %0b",
                   $time, entry_key_i, entry_valid_i, list_length_i, changed_i);
          fail_count_o++;
        end else begin
          want = results_due.pop_front();
          check_field("entry_key", 32'(want.key), 32'(entry_key_i));
          check_field("entry_valid", 32'(want.valid), 32'(entry_valid_i));
          check_field("list_length", 32'(want.len), 32'(list_length_i));
          check_field("changed", 32'(want.chg), 32'(changed_i));
        end
      end
      // an item taken at this edge still sees the capacity from before it
      if (start_i && !busy_i) begin
        results_due.push_back(predict_lookup(command_i, key_i, position_i));
      end
      if (cfg_valid_i && cfg_ready_i) cap_reg = cfg_data_i;
      pending_o = results_due.size();
    end
  end

endmodule

/* test/tb_mru_history_list.sv */
// testbench top for the mru history list: stimulus, watchdog and verdict
`timescale 1ns / 100ps

module tb_mru_history_list;
  import mhl_pkg::*;

  // cycles without any handshake before the run is declared hung
  localparam int WatchdogLimit = 200;
  localparam int PoolSize      = 20;

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  logic [CmdW-1:0] command;
  logic [KeyW-1:0] key;
  logic [PosW-1:0] position;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [CapW-1:0] cfg_data;
  logic            done;
  logic [KeyW-1:0] entry_key;
  logic            entry_valid;
  logic [LenW-1:0] list_length;
  logic            changed;

  int              fail_count;
  int              pending;
  int              quiet_cycles;

  // keys reused often, so adds hit existing entries and removes find their key
  logic [KeyW-1:0] key_pool [PoolSize];
  logic [KeyW-1:0] last_added;
  // capacity per random phase: zero, saturating, extremes, then assorted
  logic [CapW-1:0] cap_plan [8];

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  mru_history_list uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start         (start),
    .busy          (busy),
    .command_i     (command),
    .key_i         (key),
    .position_i    (position),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .done_o        (done),
    .entry_key_o   (entry_key),
    .entry_valid_o (entry_valid),
    .list_length_o (list_length),
    .changed_o     (changed)
  );

  mru_history_list_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_i        (busy),
    .command_i     (command),
    .key_i         (key),
    .position_i    (position),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .done_i        (done),
    .entry_key_i   (entry_key),
    .entry_valid_i (entry_valid),
    .list_length_i (list_length),
    .changed_i     (changed),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // watchdog: any item, result or register write counts as progress
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  // present one item and hold it until taken; start stays high for the next call
  task automatic issue(logic [CmdW-1:0] cmd, logic [KeyW-1:0] k, logic [PosW-1:0] pos);
    start    <= 1'b1;
    command  <= cmd;
    key      <= k;
    position <= pos;
    if (cmd == CmdAdd) last_added = k;
    do @(posedge clk); while (busy);
  endtask

  // stop sending and wait for every outstanding result; sampled on the falling edge
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // capacity writes happen only with the list idle
  task automatic set_capacity(logic [CapW-1:0] cap);
    drain();
    cfg_data  <= cap;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // mostly adds and reads on pooled keys, some removes, rare clears, some noise keys
  task automatic random_item();
    int              pick;
    int              src;
    logic [CmdW-1:0] cmd;
    logic [KeyW-1:0] k;
    pick = $urandom_range(0, 99);
    if (pick < 45) cmd = CmdAdd;
    else if (pick < 65) cmd = CmdRemove;
    else if (pick < 97) cmd = CmdRead;
    else cmd = CmdClear;
    src = $urandom_range(0, 9);
    if (src < 6) k = key_pool[$urandom_range(0, PoolSize - 1)];
    else if (src < 8) k = last_added;   // front key, or at least a recent one
    else k = KeyW'($urandom);
    issue(cmd, k, PosW'($urandom_range(0, 15)));
  endtask

  // bursts of random length, with random gaps and the odd full pause
  task automatic random_run(int count);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      if ($urandom_range(0, 15) == 0) drain();
      repeat (burst) begin
        if (left > 0) begin
          random_item();
          left--;
        end
      end
    end
  endtask

  initial begin
    start        = 1'b0;
    command      = CmdRead;
    key          = '0;
    position     = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    last_added   = '0;
    rst_n        = 1'b0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) key_pool[i] = KeyW'($urandom);
    cap_plan = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd17, 5'd2, 5'd7, 5'd0};
    cap_plan[7] = CapW'($urandom_range(0, 31));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset capacity
    issue(CmdClear, '0, '0);            // clear of an empty list
    issue(CmdRead, '0, '0);             // read past the length
    issue(CmdRemove, 16'h1234, '0);     // remove of an absent key
    issue(CmdAdd, 16'h0000, '0);
    issue(CmdAdd, 16'hFFFF, '0);
    issue(CmdAdd, 16'hFFFF, '0);        // add of the front key
    issue(CmdAdd, 16'h0000, '0);        // older copy moves to the front
    issue(CmdRead, '0, 4'd0);
    issue(CmdRead, '0, 4'd1);
    issue(CmdRead, '0, 4'd15);
    issue(CmdRemove, 16'hFFFF, '0);
    issue(CmdRemove, 16'hFFFF, '0);
    issue(CmdClear, '0, '0);            // clear of a filled list
    for (int i = 0; i < 11; i++) issue(CmdAdd, KeyW'(16'h0100 + i), '0);
    issue(CmdRead, '0, 4'd9);
    // capacity lowered below the length: an add drops only one entry
    set_capacity(5'd3);
    issue(CmdAdd, 16'hA5A5, '0);
    issue(CmdRead, '0, 4'd3);

    // random phases, each at its own capacity
    foreach (cap_plan[i]) begin
      set_capacity(cap_plan[i]);
      random_run(110);
    end

    drain();
    repeat (4) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/mhl_pkg.sv
sv/mhl_cell.sv
sv/mru_history_list.sv
test/mru_history_list_checker.sv
test/tb_mru_history_list.sv
